// ===== hw/rtl/seven_segment_serial_display_writer_macros.svh =====
// ----------------------------------------------------------------------------
// Seven-segment display writer assertion macros
// Short forms for clocked implication checks with reset disable.
// ----------------------------------------------------------------------------
`ifndef SEVEN_SEGMENT_SERIAL_DISPLAY_WRITER_MACROS_SVH
`define SEVEN_SEGMENT_SERIAL_DISPLAY_WRITER_MACROS_SVH

// same-cycle implication
`define SSDW_AST_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ssdw assertion failed");

// next-cycle implication
`define SSDW_AST_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ssdw assertion failed");

`endif

// ===== hw/rtl/ssdw_pkg.sv =====
// ----------------------------------------------------------------------------
// ssdw_pkg
// Shared types, command codes and the segment glyph table.
// ----------------------------------------------------------------------------
package ssdw_pkg;

  localparam int DIGITS_DEF = 4;

  localparam int ACT_W       = 2;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 8;

  localparam logic [1:0] ACT_TICK   = 2'd0;
  localparam logic [1:0] ACT_NUMBER = 2'd1;
  localparam logic [1:0] ACT_BRIGHT = 2'd2;
  localparam logic [1:0] ACT_DIGIT  = 2'd3;

  localparam logic [7:0] CMD_WRITE  = 8'h40;
  localparam logic [7:0] CMD_BRIGHT = 8'h88;
  localparam logic [7:0] CMD_ADDR   = 8'hC0;

  typedef struct packed {
    logic rejected;
    logic busy;
    logic drive;
    logic data;
    logic clock;
  } ssdw_res_t;

  function automatic logic [7:0] glyph(input logic [3:0] val);
    logic [7:0] seg;
    unique case (val)
      4'h0: seg = 8'h3F;
      4'h1: seg = 8'h06;
      4'h2: seg = 8'h5B;
      4'h3: seg = 8'h4F;
      4'h4: seg = 8'h66;
      4'h5: seg = 8'h6D;
      4'h6: seg = 8'h7D;
      4'h7: seg = 8'h07;
      4'h8: seg = 8'h7F;
      4'h9: seg = 8'h6F;
      4'hA: seg = 8'h77;
      4'hB: seg = 8'h7C;
      4'hC: seg = 8'h39;
      4'hD: seg = 8'h5E;
      4'hE: seg = 8'h79;
      default: seg = 8'h71;
    endcase
    return seg;
  endfunction

endpackage

// ===== hw/rtl/ssdw_bcd.sv =====
// ----------------------------------------------------------------------------
// ssdw_bcd
// Split a number into decimal digits, one per cycle, least significant
// first, and write each digit's segment byte into the frame store.
// ----------------------------------------------------------------------------
module ssdw_bcd
  import ssdw_pkg::*;
#(
  parameter int DIGITS = DIGITS_DEF,
  parameter int IDX_W  = 3
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [15:0]      number,
  output logic             wr_en,
  output logic [IDX_W-1:0] wr_idx,
  output logic [7:0]       wr_byte
);

  localparam int CNT_W = (DIGITS > 1) ? $clog2(DIGITS) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIGITS - 1);
  localparam logic [IDX_W-1:0] IDX_TOP  = IDX_W'(DIGITS + 1);

  logic             run_r;
  logic [CNT_W-1:0] cnt_r;
  logic [15:0]      rem_r;
  logic [31:0]      prod;
  logic [12:0]      quot;
  logic [15:0]      quot_x10;
  logic [15:0]      diff;

  // divide by ten through the reciprocal, exact over 16 bits
  assign prod     = rem_r * 32'd52429;
  assign quot     = prod[31:19];
  assign quot_x10 = {quot, 3'b000} + {2'b00, quot, 1'b0};
  assign diff     = rem_r - quot_x10;

  assign wr_en   = run_r;
  assign wr_idx  = IDX_TOP - IDX_W'(cnt_r);
  assign wr_byte = glyph(diff[3:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      cnt_r <= '0;
    end else if (start) begin
      run_r <= 1'b1;
      cnt_r <= '0;
    end else if (run_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == CNT_LAST) begin
        run_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= number;
    end else if (run_r) begin
      rem_r <= {3'b000, quot};
    end
  end

endmodule

// ===== hw/rtl/ssdw_core.sv =====
// ----------------------------------------------------------------------------
// ssdw_core
// Command decode, frame store and the pin step sequencer. One transfer
// updates the state and yields one result in the same cycle.
// ----------------------------------------------------------------------------
module ssdw_core
  import ssdw_pkg::*;
#(
  parameter int DIGITS = DIGITS_DEF,
  parameter int IDX_W  = 3
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             acc,
  input  logic [1:0]       action,
  input  logic [15:0]      number,
  input  logic [2:0]       level,
  input  logic [3:0]       digit_value,
  input  logic [1:0]       position,
  input  logic             data_line_in,
  input  logic             dig_wr_en,
  input  logic [IDX_W-1:0] dig_wr_idx,
  input  logic [7:0]       dig_wr_byte,
  output logic             conv_start,
  output logic [15:0]      conv_number,
  output ssdw_res_t        res
);

  localparam int FRAME_MAX = DIGITS + 2;
  localparam int LEN_W     = $clog2(FRAME_MAX + 1);

  localparam logic [LEN_W-1:0] LEN_NUMBER = LEN_W'(DIGITS + 2);
  localparam logic [LEN_W-1:0] LEN_BRIGHT = LEN_W'(1);
  localparam logic [LEN_W-1:0] LEN_DIGIT  = LEN_W'(3);
  localparam logic [LEN_W-1:0] LEN_FRAME  = LEN_W'(FRAME_MAX);
  localparam logic [2:0]       ADDR_TOP   = 3'(DIGITS - 1);

  localparam logic [3:0] PH_IDLE     = 4'd0;
  localparam logic [3:0] PH_START_A  = 4'd1;
  localparam logic [3:0] PH_START_B  = 4'd2;
  localparam logic [3:0] PH_START_C  = 4'd3;
  localparam logic [3:0] PH_BIT_LOW  = 4'd4;
  localparam logic [3:0] PH_BIT_HIGH = 4'd5;
  localparam logic [3:0] PH_ACK_REL  = 4'd6;
  localparam logic [3:0] PH_ACK_SMP  = 4'd7;
  localparam logic [3:0] PH_ACK_LOW  = 4'd8;
  localparam logic [3:0] PH_STOP_A   = 4'd9;
  localparam logic [3:0] PH_STOP_B   = 4'd10;
  localparam logic [3:0] PH_STOP_C   = 4'd11;

  logic [3:0]       phase_r,  phase_nxt;
  logic [IDX_W-1:0] byte_r,   byte_nxt;
  logic [2:0]       bit_r,    bit_nxt;
  logic [7:0]       shift_r,  shift_nxt;
  logic             clk_r,    clk_nxt;
  logic             dat_r,    dat_nxt;
  logic             drv_r,    drv_nxt;
  logic [LEN_W-1:0] len_r,    len_nxt;
  logic             split_r,  split_nxt;
  logic [7:0]       frame_r [FRAME_MAX];

  logic             rejected;
  logic             ld_we0, ld_we1, ld_we2;
  logic [7:0]       ld_b0, ld_b1, ld_b2;
  logic [LEN_W-1:0] rd_pos;
  logic [7:0]       rd_byte;
  logic             byte_done;
  logic [2:0]       bit_inc;

  assign rd_pos    = LEN_W'(byte_r) + 1'b1;
  assign rd_byte   = (rd_pos < LEN_FRAME) ? frame_r[rd_pos[IDX_W-1:0]] : 8'h00;
  assign byte_done = (split_r && (rd_pos == LEN_W'(1))) || (rd_pos >= len_r);
  assign bit_inc   = bit_r + 1'b1;

  assign conv_number = number;

  always_comb begin
    phase_nxt  = phase_r;
    byte_nxt   = byte_r;
    bit_nxt    = bit_r;
    shift_nxt  = shift_r;
    clk_nxt    = clk_r;
    dat_nxt    = dat_r;
    drv_nxt    = drv_r;
    len_nxt    = len_r;
    split_nxt  = split_r;
    rejected   = 1'b0;
    conv_start = 1'b0;
    ld_we0     = 1'b0;
    ld_we1     = 1'b0;
    ld_we2     = 1'b0;
    ld_b0      = CMD_WRITE;
    ld_b1      = CMD_ADDR;
    ld_b2      = glyph(digit_value);

    if (acc) begin
      if (action == ACT_TICK) begin
        unique case (phase_r)
          PH_IDLE: begin
          end
          PH_START_A: begin
            clk_nxt   = 1'b1;
            dat_nxt   = 1'b1;
            drv_nxt   = 1'b1;
            phase_nxt = PH_START_B;
          end
          PH_START_B: begin
            dat_nxt   = 1'b0;
            drv_nxt   = 1'b1;
            phase_nxt = PH_START_C;
          end
          PH_START_C: begin
            clk_nxt   = 1'b0;
            bit_nxt   = 3'd0;
            phase_nxt = PH_BIT_LOW;
          end
          PH_BIT_LOW: begin
            clk_nxt   = 1'b0;
            dat_nxt   = shift_r[0];
            drv_nxt   = 1'b1;
            phase_nxt = PH_BIT_HIGH;
          end
          PH_BIT_HIGH: begin
            clk_nxt   = 1'b1;
            shift_nxt = {1'b0, shift_r[7:1]};
            bit_nxt   = bit_inc;
            phase_nxt = (bit_inc == 3'd0) ? PH_ACK_REL : PH_BIT_LOW;
          end
          PH_ACK_REL: begin
            clk_nxt   = 1'b0;
            dat_nxt   = 1'b0;
            drv_nxt   = 1'b0;
            phase_nxt = PH_ACK_SMP;
          end
          PH_ACK_SMP, PH_ACK_LOW: begin
            if ((phase_r == PH_ACK_SMP) && !data_line_in) begin
              clk_nxt   = 1'b1;
              phase_nxt = PH_ACK_LOW;
            end else begin
              if (phase_r == PH_ACK_LOW) begin
                clk_nxt = 1'b0;
              end
              if (byte_done) begin
                phase_nxt = PH_STOP_A;
              end else begin
                byte_nxt  = rd_pos[IDX_W-1:0];
                shift_nxt = rd_byte;
                bit_nxt   = 3'd0;
                phase_nxt = PH_BIT_LOW;
              end
            end
          end
          PH_STOP_A: begin
            clk_nxt   = 1'b0;
            dat_nxt   = 1'b0;
            drv_nxt   = 1'b1;
            phase_nxt = PH_STOP_B;
          end
          PH_STOP_B: begin
            clk_nxt   = 1'b1;
            phase_nxt = PH_STOP_C;
          end
          PH_STOP_C: begin
            dat_nxt = 1'b1;
            drv_nxt = 1'b1;
            if (rd_pos < len_r) begin
              byte_nxt  = rd_pos[IDX_W-1:0];
              shift_nxt = rd_byte;
              phase_nxt = PH_START_A;
            end else begin
              phase_nxt = PH_IDLE;
            end
          end
          default: begin
            phase_nxt = PH_IDLE;
          end
        endcase
      end else if (phase_r != PH_IDLE) begin
        rejected = 1'b1;
      end else begin
        byte_nxt  = '0;
        bit_nxt   = 3'd0;
        phase_nxt = PH_START_A;
        ld_we0    = 1'b1;
        unique case (action)
          ACT_NUMBER: begin
            ld_we1     = 1'b1;
            len_nxt    = LEN_NUMBER;
            split_nxt  = 1'b1;
            conv_start = 1'b1;
          end
          ACT_BRIGHT: begin
            ld_b0     = CMD_BRIGHT + {5'b00000, level};
            len_nxt   = LEN_BRIGHT;
            split_nxt = 1'b0;
          end
          default: begin
            ld_we1    = 1'b1;
            ld_we2    = 1'b1;
            ld_b1     = CMD_ADDR | {5'b00000, ADDR_TOP - {1'b0, position}};
            len_nxt   = LEN_DIGIT;
            split_nxt = 1'b1;
          end
        endcase
        shift_nxt = ld_b0;
      end
    end
  end

  assign res.clock    = clk_nxt;
  assign res.data     = dat_nxt;
  assign res.drive    = drv_nxt;
  assign res.busy     = (phase_nxt != PH_IDLE);
  assign res.rejected = rejected;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      byte_r  <= '0;
      bit_r   <= 3'd0;
      shift_r <= 8'h00;
      clk_r   <= 1'b1;
      dat_r   <= 1'b1;
      drv_r   <= 1'b1;
      len_r   <= '0;
      split_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      byte_r  <= byte_nxt;
      bit_r   <= bit_nxt;
      shift_r <= shift_nxt;
      clk_r   <= clk_nxt;
      dat_r   <= dat_nxt;
      drv_r   <= drv_nxt;
      len_r   <= len_nxt;
      split_r <= split_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_we0) begin
      frame_r[0] <= ld_b0;
    end
    if (ld_we1) begin
      frame_r[1] <= ld_b1;
    end
    if (ld_we2) begin
      frame_r[2] <= ld_b2;
    end
    if (dig_wr_en) begin
      frame_r[dig_wr_idx] <= dig_wr_byte;
    end
  end

endmodule

// ===== hw/rtl/ssdw_outq.sv =====
// ----------------------------------------------------------------------------
// ssdw_outq
// Result register with one skid entry behind it.
// ----------------------------------------------------------------------------
module ssdw_outq
  import ssdw_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  ssdw_res_t push_res,
  output logic      space,
  output logic      out_valid,
  input  logic      out_ready,
  output ssdw_res_t out_res
);

  logic      head_vld_r;
  logic      skid_vld_r;
  ssdw_res_t head_r;
  ssdw_res_t skid_r;
  logic      pop;

  assign pop       = head_vld_r && out_ready;
  assign space     = !skid_vld_r;
  assign out_valid = head_vld_r;
  assign out_res   = head_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (skid_vld_r) begin
      if (pop) begin
        skid_vld_r <= 1'b0;
      end
    end else if (push) begin
      if (head_vld_r && !pop) begin
        skid_vld_r <= 1'b1;
      end else begin
        head_vld_r <= 1'b1;
      end
    end else if (pop) begin
      head_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_vld_r) begin
      if (pop) begin
        head_r <= skid_r;
      end
    end else if (push) begin
      if (head_vld_r && !pop) begin
        skid_r <= push_res;
      end else begin
        head_r <= push_res;
      end
    end
  end

endmodule

// ===== hw/rtl/seven_segment_serial_display_writer.sv =====
// ----------------------------------------------------------------------------
// seven_segment_serial_display_writer
// Two-wire seven-segment display link driver, one pin step per tick.
//
//   channel | dir | tdata                                  | tuser
//   in_     | in  | number, level, digit_value, position,   | action
//           |     | data_line_in                           |
//   out_    | out | clock_line, data_line, data_drive,      | -
//           |     | busy_res, rejected                     |
//
// One transfer per cycle while in_tready is high; each result is registered
// in the output head register, or in the skid entry behind a held head.
// A show-number command has ssdw_bcd write its digit bytes into the frame.
// Two results can wait on the output before in_tready drops.
// Reset: pins high and driven, sequencer idle, output empty.
// ----------------------------------------------------------------------------
module seven_segment_serial_display_writer
  import ssdw_pkg::*;
#(
  parameter int DIGITS = DIGITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // number[15:0], level[18:16], digit_value[22:19], position[24:23],
  // data_line_in[25]
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // action[1:0]
  input  logic [ACT_W-1:0]       in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // clock_line[0], data_line[1], data_drive[2], busy_res[3], rejected[4]
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  localparam int IDX_W = $clog2(DIGITS + 2);

  logic             acc;
  logic             conv_start;
  logic [15:0]      conv_number;
  logic             dig_wr_en;
  logic [IDX_W-1:0] dig_wr_idx;
  logic [7:0]       dig_wr_byte;
  ssdw_res_t        core_res;
  ssdw_res_t        q_res;

  assign acc = in_tvalid && in_tready;

  ssdw_bcd #(
    .DIGITS (DIGITS),
    .IDX_W  (IDX_W)
  ) u_bcd (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (conv_start),
    .number  (conv_number),
    .wr_en   (dig_wr_en),
    .wr_idx  (dig_wr_idx),
    .wr_byte (dig_wr_byte)
  );

  ssdw_core #(
    .DIGITS (DIGITS),
    .IDX_W  (IDX_W)
  ) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .acc          (acc),
    .action       (in_tuser),
    .number       (in_tdata[15:0]),
    .level        (in_tdata[18:16]),
    .digit_value  (in_tdata[22:19]),
    .position     (in_tdata[24:23]),
    .data_line_in (in_tdata[25]),
    .dig_wr_en    (dig_wr_en),
    .dig_wr_idx   (dig_wr_idx),
    .dig_wr_byte  (dig_wr_byte),
    .conv_start   (conv_start),
    .conv_number  (conv_number),
    .res          (core_res)
  );

  ssdw_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (acc),
    .push_res  (core_res),
    .space     (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (q_res)
  );

  assign out_tdata = {3'b000, q_res};

endmodule

// ===== hw/rtl/ssdw_checker.sv =====
// ----------------------------------------------------------------------------
// ssdw_checker
// Port-level checks on the display writer, bound to the top level.
// ----------------------------------------------------------------------------
`include "seven_segment_serial_display_writer_macros.svh"

module ssdw_checker
  import ssdw_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  // stalled result holds
  `SSDW_AST_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

  // accepted transfer yields a result
  `SSDW_AST_NXT(a_xfer_res, in_tvalid && in_tready, out_tvalid)

  // reject only while a frame runs
  `SSDW_AST_IMP(a_rej_busy, out_tvalid && out_tdata[4], out_tdata[3])

  // released data pin reads as low
  `SSDW_AST_IMP(a_rel_low, out_tvalid && !out_tdata[2], !out_tdata[1])

  // idle link rests high and driven
  `SSDW_AST_IMP(a_idle_pins, out_tvalid && !out_tdata[3], out_tdata[2:0] == 3'b111)

endmodule

bind seven_segment_serial_display_writer ssdw_checker u_ssdw_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: seven-segment serial display writer testbench
// A generator builds command frames (show number, set brightness, show
// digit), each followed by the ticks that clock the frame out on the two pin
// lines. The ack line, misplaced commands and idle ticks are randomized. A
// stream driver and a result monitor run with random gaps and one long
// receiver hold-off. The monitor checks every pin state against a cycle
// model of the link sequencer.
// ----------------------------------------------------------------------------
module tb_top;
  import ssdw_pkg::*;

  localparam int DIGS      = DIGITS_DEF;
  localparam int FRAME_MAX = DIGS + 2;
  localparam int ITEMS     = 1550;
  localparam int HOLD_AT   = 700;
  localparam int HOLD_LEN  = 400;
  localparam int LIMIT     = 1000000;

  localparam logic [15:0][7:0] SEG_TAB = {
    8'h71, 8'h79, 8'h5E, 8'h39, 8'h7C, 8'h77, 8'h6F, 8'h7F,
    8'h07, 8'h7D, 8'h6D, 8'h66, 8'h4F, 8'h5B, 8'h06, 8'h3F
  };

  typedef enum logic [3:0] {
    ST_IDLE, ST_START_HI, ST_START_DAT, ST_START_CLK, ST_BIT_SET, ST_BIT_CLK,
    ST_ACK_RELEASE, ST_ACK_SAMPLE, ST_ACK_PULSE, ST_STOP_LOW, ST_STOP_CLK,
    ST_STOP_DAT
  } link_step_t;

  typedef struct packed {
    link_step_t                   step;
    logic [FRAME_MAX-1:0][7:0]    frame;
    logic [2:0]                   byte_idx;
    logic [2:0]                   bit_idx;
    logic [7:0]                   shreg;
    logic                         scl;
    logic                         sda;
    logic                         sdrv;
    logic [2:0]                   frame_len;
    logic [2:0]                   split;
  } link_state_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] number;
    logic [2:0]  level;
    logic [3:0]  digit;
    logic [1:0]  pos;
    logic        din;
  } cmd_item_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [ACT_W-1:0]       in_tuser = ACT_TICK;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  cmd_item_t   stim_q[$];
  ssdw_res_t   pin_expect_q[$];
  link_state_t plan_link;
  link_state_t check_link;

  cmd_item_t   tx_cur;
  int          tx_wait = 0;
  int          tx_calm = 0;
  int          rx_stall = 0;
  int          rx_calm = 0;
  int          rx_hold = 0;
  bit          hold_done = 1'b0;
  ssdw_res_t   rx_got;
  ssdw_res_t   rx_want;

  int n_useful = 0;
  int n_number = 0;
  int n_bright = 0;
  int n_digit = 0;
  int n_refused = 0;
  int n_idle_tick = 0;
  int n_nak = 0;
  int n_checked = 0;
  int n_err = 0;
  int n_cycles = 0;

  seven_segment_serial_display_writer uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #5 clk = ~clk;

  function automatic link_state_t link_reset();
    link_state_t s;
    s = '0;
    s.step = ST_IDLE;
    s.scl = 1'b1;
    s.sda = 1'b1;
    s.sdrv = 1'b1;
    return s;
  endfunction

  function automatic logic [7:0] frame_byte(input link_state_t s, input int idx);
    return (idx < FRAME_MAX) ? s.frame[idx] : 8'h00;
  endfunction

  function automatic void next_byte(inout link_state_t s);
    int nxt;
    nxt = int'(s.byte_idx) + 1;
    if (nxt == int'(s.split) || nxt >= int'(s.frame_len)) begin
      s.step = ST_STOP_LOW;
    end else begin
      s.byte_idx = nxt[2:0];
      s.shreg = frame_byte(s, nxt);
      s.bit_idx = 3'd0;
      s.step = ST_BIT_SET;
    end
  endfunction

  function automatic void load_frame(inout link_state_t s, input cmd_item_t it);
    int n;
    int off;
    if (it.action == ACT_NUMBER) begin
      n = int'(it.number);
      s.frame[0] = CMD_WRITE;
      s.frame[1] = CMD_ADDR;
      for (int k = 0; k < DIGS; k++) begin
        s.frame[2 + DIGS - 1 - k] = SEG_TAB[n % 10];
        n = n / 10;
      end
      s.frame_len = 3'(DIGS + 2);
      s.split = 3'd1;
    end else if (it.action == ACT_BRIGHT) begin
      s.frame[0] = CMD_BRIGHT + {5'd0, it.level};
      s.frame_len = 3'd1;
      s.split = 3'd0;
    end else begin
      off = DIGS - 1 - int'(it.pos);
      s.frame[0] = CMD_WRITE;
      s.frame[1] = CMD_ADDR | {5'd0, off[2:0]};
      s.frame[2] = SEG_TAB[it.digit];
      s.frame_len = 3'd3;
      s.split = 3'd1;
    end
    s.byte_idx = 3'd0;
    s.bit_idx = 3'd0;
    s.shreg = s.frame[0];
    s.step = ST_START_HI;
  endfunction

  function automatic void pin_step(inout link_state_t s, input logic din);
    int nxt;
    case (s.step)
      ST_START_HI: begin
        s.scl = 1'b1; s.sda = 1'b1; s.sdrv = 1'b1;
        s.step = ST_START_DAT;
      end
      ST_START_DAT: begin
        s.sda = 1'b0; s.sdrv = 1'b1;
        s.step = ST_START_CLK;
      end
      ST_START_CLK: begin
        s.scl = 1'b0;
        s.bit_idx = 3'd0;
        s.step = ST_BIT_SET;
      end
      ST_BIT_SET: begin
        s.scl = 1'b0; s.sda = s.shreg[0]; s.sdrv = 1'b1;
        s.step = ST_BIT_CLK;
      end
      ST_BIT_CLK: begin
        s.scl = 1'b1;
        s.shreg = s.shreg >> 1;
        s.bit_idx = s.bit_idx + 3'd1;
        s.step = (s.bit_idx == 3'd0) ? ST_ACK_RELEASE : ST_BIT_SET;
      end
      ST_ACK_RELEASE: begin
        s.scl = 1'b0; s.sda = 1'b0; s.sdrv = 1'b0;
        s.step = ST_ACK_SAMPLE;
      end
      ST_ACK_SAMPLE: begin
        if (!din) begin
          s.scl = 1'b1;
          s.step = ST_ACK_PULSE;
        end else begin
          next_byte(s);
        end
      end
      ST_ACK_PULSE: begin
        s.scl = 1'b0;
        next_byte(s);
      end
      ST_STOP_LOW: begin
        s.scl = 1'b0; s.sda = 1'b0; s.sdrv = 1'b1;
        s.step = ST_STOP_CLK;
      end
      ST_STOP_CLK: begin
        s.scl = 1'b1;
        s.step = ST_STOP_DAT;
      end
      ST_STOP_DAT: begin
        s.sda = 1'b1; s.sdrv = 1'b1;
        nxt = int'(s.byte_idx) + 1;
        if (nxt < int'(s.frame_len)) begin
          s.byte_idx = nxt[2:0];
          s.shreg = frame_byte(s, nxt);
          s.step = ST_START_HI;
        end else begin
          s.step = ST_IDLE;
        end
      end
      default: s.step = ST_IDLE;
    endcase
  endfunction

  function automatic ssdw_res_t link_advance(inout link_state_t s, input cmd_item_t it);
    ssdw_res_t r;
    logic rej;
    rej = 1'b0;
    if (it.action == ACT_TICK) begin
      if (s.step != ST_IDLE) pin_step(s, it.din);
    end else if (s.step != ST_IDLE) begin
      rej = 1'b1;
    end else begin
      load_frame(s, it);
    end
    r.clock = s.scl;
    r.data = s.sda;
    r.drive = s.sdrv;
    r.busy = (s.step != ST_IDLE);
    r.rejected = rej;
    return r;
  endfunction

  function automatic int draw_idle(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      calm = $urandom_range(20, 80);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic cmd_item_t rand_item(input logic [1:0] act);
    cmd_item_t it;
    it.action = act;
    it.number = 16'($urandom_range(0, 65535));
    it.level = 3'($urandom_range(0, 7));
    it.digit = 4'($urandom_range(0, 15));
    it.pos = 2'($urandom_range(0, 3));
    it.din = 1'($urandom_range(0, 1));
    return it;
  endfunction

  task automatic push_item(input cmd_item_t it);
    if (it.action == ACT_TICK) begin
      if (plan_link.step == ST_IDLE) n_idle_tick++;
      else n_useful++;
      if (plan_link.step == ST_ACK_SAMPLE && it.din) n_nak++;
    end else if (plan_link.step != ST_IDLE) begin
      n_refused++;
    end else begin
      n_useful++;
      case (it.action)
        ACT_NUMBER: n_number++;
        ACT_BRIGHT: n_bright++;
        default:    n_digit++;
      endcase
    end
    void'(link_advance(plan_link, it));
    stim_q.push_back(it);
  endtask

  task automatic finish_frame(input int ack_pct, input int noise_pct);
    cmd_item_t t;
    while (plan_link.step != ST_IDLE) begin
      if ($urandom_range(0, 99) < noise_pct) push_item(rand_item(2'($urandom_range(1, 3))));
      t = rand_item(ACT_TICK);
      t.din = ($urandom_range(0, 99) < ack_pct) ? 1'b0 : 1'b1;
      push_item(t);
    end
  endtask

  task automatic run_frame(input cmd_item_t cmd, input int ack_pct, input int noise_pct);
    finish_frame(50, 0);
    push_item(cmd);
    finish_frame(ack_pct, noise_pct);
  endtask

  task automatic wait_drained();
    while (stim_q.size() != 0 || in_tvalid || pin_expect_q.size() != 0) @(negedge clk);
  endtask

  task automatic check_field(input string name, input logic want, input logic got);
    if (got !== want) begin
      n_err++;
      $display("%0t: %s mismatch, expected %0b actual %0b", $time, name, want, got);
    end
  endtask

  // stream driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) pin_expect_q.push_back(link_advance(check_link, tx_cur));
      if (!in_tvalid || in_tready) begin
        if (tx_wait > 0) begin
          tx_wait--;
          in_tvalid <= 1'b0;
        end else if (stim_q.size() != 0) begin
          tx_cur = stim_q.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= {6'd0, tx_cur.din, tx_cur.pos, tx_cur.digit, tx_cur.level,
                       tx_cur.number};
          in_tuser <= tx_cur.action;
          tx_wait = draw_idle(tx_calm);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        rx_got = ssdw_res_t'(out_tdata[4:0]);
        if (pin_expect_q.size() == 0) begin
          n_err++;
          $display("%0t: unexpected result, expected none actual %05b", $time, rx_got);
        end else begin
          rx_want = pin_expect_q.pop_front();
          n_checked++;
          check_field("clock_line", rx_want.clock, rx_got.clock);
          check_field("data_line", rx_want.data, rx_got.data);
          check_field("data_drive", rx_want.drive, rx_got.drive);
          check_field("busy", rx_want.busy, rx_got.busy);
          check_field("rejected", rx_want.rejected, rx_got.rejected);
        end
      end
      if (!hold_done && n_checked >= HOLD_AT) begin
        hold_done = 1'b1;
        rx_hold = HOLD_LEN;
      end
      if (rx_hold > 0) begin
        rx_hold--;
        out_tready <= 1'b0;
      end else if (rx_stall > 0) begin
        rx_stall--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        rx_stall = draw_idle(rx_calm);
      end
    end
  end

  always @(posedge clk) begin
    n_cycles++;
    if (n_cycles >= LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    cmd_item_t cmd;
    int half;
    bit paused;
    int pick;

    plan_link = link_reset();
    check_link = link_reset();
    paused = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    push_item(rand_item(ACT_TICK));
    cmd = rand_item(ACT_NUMBER);
    cmd.number = 16'd0;
    run_frame(cmd, 100, 0);
    cmd.number = 16'hFFFF;
    run_frame(cmd, 0, 0);
    cmd = rand_item(ACT_BRIGHT);
    cmd.level = 3'd0;
    run_frame(cmd, 0, 0);
    cmd.level = 3'd7;
    run_frame(cmd, 100, 0);
    cmd = rand_item(ACT_DIGIT);
    cmd.digit = 4'd0;
    cmd.pos = 2'd3;
    push_item(cmd);
    push_item(rand_item(ACT_NUMBER));
    push_item(rand_item(ACT_BRIGHT));
    push_item(rand_item(ACT_DIGIT));
    finish_frame(50, 0);
    cmd.digit = 4'd15;
    cmd.pos = 2'd0;
    run_frame(cmd, 100, 0);
    push_item(rand_item(ACT_TICK));
    wait_drained();

    half = n_useful + (ITEMS - n_useful) / 2;
    while (n_useful < ITEMS) begin
      if (!paused && n_useful >= half) begin
        finish_frame(50, 0);
        wait_drained();
        paused = 1'b1;
      end
      if ($urandom_range(0, 99) < 85) begin
        pick = $urandom_range(0, 3);
        run_frame(rand_item(2'($urandom_range(1, 3))),
                  (pick == 0) ? 0 : (pick == 1) ? 50 : (pick == 2) ? 90 : 100,
                  ($urandom_range(0, 1) == 0) ? 0 : 5);
      end else begin
        repeat ($urandom_range(1, 8)) push_item(rand_item(2'($urandom_range(0, 3))));
      end
    end
    finish_frame(50, 0);
    wait_drained();
    repeat (20) @(posedge clk);

    $display("Frames sent: %0d number, %0d brightness, %0d digit; %0d acks withheld.",
             n_number, n_bright, n_digit, n_nak);
    $display("Busy commands refused: %0d, idle ticks: %0d, results compared: %0d.",
             n_refused, n_idle_tick, n_checked);
    if (n_err == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
